// ===== hw/rtl/ppma_pkg.sv =====
package ppma_pkg;

  localparam int MAX_PIXELS_X = 128;
  localparam int MAX_PIXELS_Y = 128;
  localparam int MAX_WINDOW   = 16;
  localparam int SAMPLE_BITS  = 16;

  localparam int PIXEL_W = 16;
  localparam int PED_W   = 24;
  localparam int WIN_W   = 5;
  localparam int CNT_W   = 8;
  localparam int FRAC_W  = 8;

  localparam int X_W    = (MAX_PIXELS_X > 1) ? $clog2(MAX_PIXELS_X) : 1;
  localparam int Y_W    = (MAX_PIXELS_Y > 1) ? $clog2(MAX_PIXELS_Y) : 1;
  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int PIXELS = MAX_PIXELS_X * MAX_PIXELS_Y;
  localparam int CELLS  = MAX_WINDOW * PIXELS;
  localparam int PIX_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int QUO_W  = SUM_W + FRAC_W;

  localparam int RST_WINDOW  = 1;
  localparam int RST_COUNT_X = (MAX_PIXELS_X < 128) ? MAX_PIXELS_X : 128;
  localparam int RST_COUNT_Y = (MAX_PIXELS_Y < 128) ? MAX_PIXELS_Y : 128;

  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 4;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_COUNT_X = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_COUNT_Y = REG_IDX_W'(2);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [PIX_W-1:0]       sum_addr;
    logic [CELL_W-1:0]      ring_addr;
    logic                   first_frame;
    logic                   ped_valid;
    logic                   last;
  } ppma_job_t;

  typedef struct packed {
    logic ped_valid;
    logic last;
  } ppma_tag_t;

endpackage

// ===== hw/rtl/ppma_pix_if.sv =====
interface ppma_pix_if;
  import ppma_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

// ===== hw/rtl/ppma_ped_if.sv =====
interface ppma_ped_if;
  import ppma_pkg::*;

  logic             valid;
  logic             ready;
  logic [PED_W-1:0] pedestal;
  logic             pedestal_valid;
  logic             end_of_frame;

  modport source (output valid, output pedestal, output pedestal_valid,
                  output end_of_frame, input ready);
  modport sink (input valid, input pedestal, input pedestal_valid,
                input end_of_frame, output ready);
endinterface

// ===== hw/rtl/ppma_front.sv =====
module ppma_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ppma_pkg::ADDR_W-1:0]    paddr,
  input  logic [ppma_pkg::DATA_W-1:0]    pwdata,
  output logic [ppma_pkg::DATA_W-1:0]    prdata,
  input  logic                           pix_valid_i,
  input  logic [ppma_pkg::PIXEL_W-1:0]   pixel_value_i,
  output logic                           pix_ready_o,
  input  logic                           fifo_full_i,
  output logic                           push_o,
  output ppma_pkg::ppma_job_t            job_o,
  output logic [ppma_pkg::WIN_W-1:0]     window_o
);
  import ppma_pkg::*;

  logic [WIN_W-1:0]     window_q, window_d;
  logic [CNT_W-1:0]     count_x_q, count_x_d;
  logic [CNT_W-1:0]     count_y_q, count_y_d;
  logic [WIN_W-1:0]     frames_seen_q, frames_seen_d;
  logic [SLOT_W-1:0]    ring_slot_q, ring_slot_d;
  logic [X_W-1:0]       scan_x_q, scan_x_d;
  logic [Y_W-1:0]       scan_y_q, scan_y_d;

  logic                 cfg_we;
  logic [REG_IDX_W-1:0] reg_idx;
  logic [WIN_W-1:0]     wr_win;
  logic [CNT_W-1:0]     wr_cnt;
  logic [WIN_W-1:0]     win_clamped;
  logic [CNT_W-1:0]     cx_clamped;
  logic [CNT_W-1:0]     cy_clamped;
  logic                 restart;
  logic                 accept;
  logic                 last_x;
  logic                 last_y;
  logic [31:0]          x_next;
  logic [31:0]          y_next;
  logic [31:0]          slot_next;
  logic [31:0]          pix_lin;
  logic [31:0]          cell_lin;

  assign cfg_we  = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_win  = pwdata[WIN_W-1:0];
  assign wr_cnt  = pwdata[CNT_W-1:0];

  // Out-of-range writes are pulled into the legal range: zero reads as one.
  always_comb begin
    if (wr_win == '0) begin
      win_clamped = WIN_W'(1);
    end else if (32'(wr_win) > 32'(MAX_WINDOW)) begin
      win_clamped = WIN_W'(MAX_WINDOW);
    end else begin
      win_clamped = wr_win;
    end
    if (wr_cnt == '0) begin
      cx_clamped = CNT_W'(1);
    end else if (32'(wr_cnt) > 32'(MAX_PIXELS_X)) begin
      cx_clamped = CNT_W'(MAX_PIXELS_X);
    end else begin
      cx_clamped = wr_cnt;
    end
    if (wr_cnt == '0) begin
      cy_clamped = CNT_W'(1);
    end else if (32'(wr_cnt) > 32'(MAX_PIXELS_Y)) begin
      cy_clamped = CNT_W'(MAX_PIXELS_Y);
    end else begin
      cy_clamped = wr_cnt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW:  prdata = DATA_W'(window_q);
      REG_COUNT_X: prdata = DATA_W'(count_x_q);
      REG_COUNT_Y: prdata = DATA_W'(count_y_q);
      default:     prdata = '0;
    endcase
  end

  assign accept      = pix_valid_i & ~fifo_full_i;
  assign pix_ready_o = ~fifo_full_i;
  assign push_o      = accept;
  assign window_o    = window_q;

  always_comb begin
    x_next    = 32'(scan_x_q) + 32'd1;
    y_next    = 32'(scan_y_q) + 32'd1;
    slot_next = 32'(ring_slot_q) + 32'd1;
    last_x    = x_next >= 32'(count_x_q);
    last_y    = y_next >= 32'(count_y_q);
    pix_lin   = 32'(scan_x_q) * 32'(MAX_PIXELS_Y) + 32'(scan_y_q);
    cell_lin  = 32'(ring_slot_q) * 32'(PIXELS) + pix_lin;

    job_o.sample      = SAMPLE_BITS'(pixel_value_i);
    job_o.sum_addr    = PIX_W'(pix_lin);
    job_o.ring_addr   = CELL_W'(cell_lin);
    job_o.first_frame = frames_seen_q == '0;
    job_o.ped_valid   = frames_seen_q >= window_q;
    job_o.last        = last_x & last_y;
  end

  always_comb begin
    window_d      = window_q;
    count_x_d     = count_x_q;
    count_y_d     = count_y_q;
    frames_seen_d = frames_seen_q;
    ring_slot_d   = ring_slot_q;
    scan_x_d      = scan_x_q;
    scan_y_d      = scan_y_q;
    restart       = 1'b0;
    if (cfg_we) begin
      case (reg_idx)
        REG_WINDOW: begin
          window_d = win_clamped;
          restart  = 1'b1;
        end
        REG_COUNT_X: begin
          count_x_d = cx_clamped;
          restart   = 1'b1;
        end
        REG_COUNT_Y: begin
          count_y_d = cy_clamped;
          restart   = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
    if (restart) begin
      frames_seen_d = '0;
      ring_slot_d   = '0;
      scan_x_d      = '0;
      scan_y_d      = '0;
    end else if (accept) begin
      if (last_y) begin
        scan_y_d = '0;
        if (last_x) begin
          scan_x_d = '0;
          if (frames_seen_q < window_q) begin
            frames_seen_d = frames_seen_q + WIN_W'(1);
          end
          ring_slot_d = (slot_next >= 32'(window_q)) ? '0 : SLOT_W'(slot_next);
        end else begin
          scan_x_d = X_W'(x_next);
        end
      end else begin
        scan_y_d = Y_W'(y_next);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q      <= WIN_W'(RST_WINDOW);
      count_x_q     <= CNT_W'(RST_COUNT_X);
      count_y_q     <= CNT_W'(RST_COUNT_Y);
      frames_seen_q <= '0;
      ring_slot_q   <= '0;
      scan_x_q      <= '0;
      scan_y_q      <= '0;
    end else begin
      window_q      <= window_d;
      count_x_q     <= count_x_d;
      count_y_q     <= count_y_d;
      frames_seen_q <= frames_seen_d;
      ring_slot_q   <= ring_slot_d;
      scan_x_q      <= scan_x_d;
      scan_y_q      <= scan_y_d;
    end
  end

endmodule

// ===== hw/rtl/ppma_fifo.sv =====
module ppma_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ppma_pkg::ppma_job_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output ppma_pkg::ppma_job_t pop_data_o,
  output logic                empty_o
);
  import ppma_pkg::*;

  ppma_job_t             mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;

  assign full_o     = count_q == FIFO_CNT_W'(FIFO_DEPTH);
  assign empty_o    = count_q == '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (32'(wr_ptr_q) == FIFO_DEPTH - 1) ? '0 : wr_ptr_q + FIFO_PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (32'(rd_ptr_q) == FIFO_DEPTH - 1) ? '0 : rd_ptr_q + FIFO_PTR_W'(1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + FIFO_CNT_W'(1);
      2'b01:   count_d = count_q - FIFO_CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/ppma_div.sv =====
module ppma_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        in_valid_i,
  input  logic [ppma_pkg::QUO_W-1:0]  dividend_i,
  input  logic [ppma_pkg::WIN_W-1:0]  divisor_i,
  input  ppma_pkg::ppma_tag_t         tag_i,
  output logic                        out_valid_o,
  output logic [ppma_pkg::QUO_W-1:0]  quotient_o,
  output ppma_pkg::ppma_tag_t         tag_o
);
  import ppma_pkg::*;

  // One quotient bit per stage, most significant first; the partial
  // remainder always stays below the divisor.
  logic [QUO_W-1:0] vld_q;
  logic [WIN_W-1:0] rem_q   [QUO_W];
  logic [QUO_W-1:0] nq_q    [QUO_W];
  ppma_tag_t        tag_q   [QUO_W];
  logic [WIN_W-1:0] rem_src [QUO_W];
  logic [QUO_W-1:0] nq_src  [QUO_W];
  logic [WIN_W-1:0] rem_d   [QUO_W];
  logic [QUO_W-1:0] nq_d    [QUO_W];

  always_comb begin
    logic [WIN_W:0] trial;
    logic           fits;
    rem_src[0] = '0;
    nq_src[0]  = dividend_i;
    for (int k = 1; k < QUO_W; k++) begin
      rem_src[k] = rem_q[k-1];
      nq_src[k]  = nq_q[k-1];
    end
    for (int k = 0; k < QUO_W; k++) begin
      trial    = {rem_src[k], nq_src[k][QUO_W-1]};
      fits     = trial >= {1'b0, divisor_i};
      rem_d[k] = fits ? WIN_W'(trial - {1'b0, divisor_i}) : WIN_W'(trial);
      nq_d[k]  = {nq_src[k][QUO_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QUO_W-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      for (int k = 0; k < QUO_W; k++) begin
        rem_q[k] <= rem_d[k];
        nq_q[k]  <= nq_d[k];
      end
      for (int k = 1; k < QUO_W; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  assign out_valid_o = vld_q[QUO_W-1];
  assign quotient_o  = nq_q[QUO_W-1];
  assign tag_o       = tag_q[QUO_W-1];

endmodule

// ===== hw/rtl/ppma_back.sv =====
module ppma_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ppma_pkg::ppma_job_t         job_i,
  input  logic                        fifo_empty_i,
  output logic                        pop_o,
  input  logic [ppma_pkg::WIN_W-1:0]  window_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ppma_pkg::PED_W-1:0]  pedestal_o,
  output logic                        pedestal_valid_o,
  output logic                        end_of_frame_o
);
  import ppma_pkg::*;

  logic [SUM_W-1:0]       sum_mem  [PIXELS];
  logic [SAMPLE_BITS-1:0] ring_mem [CELLS];

  logic                   en;
  logic                   wr_en;
  logic                   s1_vld_q;
  ppma_job_t              s1_q;
  logic [SUM_W-1:0]       sum_rd_q;
  logic [SAMPLE_BITS-1:0] ring_rd_q;

  logic                   lw_vld_q;
  logic [PIX_W-1:0]       lw_sum_addr_q;
  logic [SUM_W-1:0]       lw_sum_q;
  logic [CELL_W-1:0]      lw_ring_addr_q;
  logic [SAMPLE_BITS-1:0] lw_ring_q;

  logic [SUM_W-1:0]       sum_fwd;
  logic [SUM_W-1:0]       sum_eff;
  logic [SAMPLE_BITS-1:0] ring_fwd;
  logic [SUM_W-1:0]       drop;
  logic [SUM_W-1:0]       new_sum;
  logic [QUO_W-1:0]       dividend;

  logic                   div_vld;
  logic [QUO_W-1:0]       quotient;
  ppma_tag_t              tag_in;
  ppma_tag_t              tag_out;

  assign en    = ~div_vld | out_ready_i;
  assign pop_o = en & ~fifo_empty_i;
  assign wr_en = en & s1_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      lw_vld_q <= 1'b0;
    end else begin
      if (en) begin
        s1_vld_q <= pop_o;
      end
      if (wr_en) begin
        lw_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q <= job_i;
    end
    if (wr_en) begin
      lw_sum_addr_q  <= s1_q.sum_addr;
      lw_sum_q       <= new_sum;
      lw_ring_addr_q <= s1_q.ring_addr;
      lw_ring_q      <= s1_q.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sum_mem[s1_q.sum_addr]   <= new_sum;
      ring_mem[s1_q.ring_addr] <= s1_q.sample;
    end
    if (pop_o) begin
      sum_rd_q  <= sum_mem[job_i.sum_addr];
      ring_rd_q <= ring_mem[job_i.ring_addr];
    end
  end

  // The write of the beat ahead lands on the same edge as this beat's read,
  // so the last write is forwarded when the addresses match.
  always_comb begin
    sum_fwd  = (lw_vld_q && lw_sum_addr_q == s1_q.sum_addr) ? lw_sum_q : sum_rd_q;
    ring_fwd = (lw_vld_q && lw_ring_addr_q == s1_q.ring_addr) ? lw_ring_q : ring_rd_q;
    sum_eff  = s1_q.first_frame ? '0 : sum_fwd;
    drop     = s1_q.ped_valid ? SUM_W'(ring_fwd) : '0;
    new_sum  = sum_eff - drop + SUM_W'(s1_q.sample);
    dividend = s1_q.ped_valid ? QUO_W'({sum_eff, FRAC_W'(0)}) : '0;
    tag_in.ped_valid = s1_q.ped_valid;
    tag_in.last      = s1_q.last;
  end

  ppma_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (s1_vld_q),
    .dividend_i  (dividend),
    .divisor_i   (window_i),
    .tag_i       (tag_in),
    .out_valid_o (div_vld),
    .quotient_o  (quotient),
    .tag_o       (tag_out)
  );

  assign out_valid_o      = div_vld;
  assign pedestal_o       = PED_W'(quotient);
  assign pedestal_valid_o = tag_out.ped_valid;
  assign end_of_frame_o   = tag_out.last;

endmodule

// ===== hw/rtl/per_pixel_moving_average_pedestal.sv =====
// Per-pixel moving-average pedestal.
// Samples enter on pix_i in scan order, the inner index fastest, one beat per
// pixel. Each beat yields one beat on ped_o: the mean of that pixel over the
// previous window_frames frames with 8 fraction bits, a flag that is set once
// that many frames have been seen, and an end-of-frame mark.
// Registers sit on the APB port at byte addresses 0 (window_frames),
// 4 (count_x) and 8 (count_y); a write restarts the warm-up and must be
// issued only while no beat is in flight.
// Throughput is one beat per clock while ped_o is not stalled: the sum and
// ring memories are each read and written once per beat, with the previous
// write forwarded. An accepted input beat passes through the input queue,
// the register for the memory read and sum update, and the pipelined
// restoring divider, one quotient bit per stage.
// After reset the registers hold 1, 128 and 128 and the block takes beats at
// once; no clearing pass is needed because the first frame reads sums as zero.
// When ped_o stalls, the whole back pipeline holds and the four-entry input
// queue keeps taking beats until it fills, then pix_i.ready drops.
module per_pixel_moving_average_pedestal (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ppma_pix_if.sink                    pix_i,
  ppma_ped_if.source                  ped_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppma_pkg::ADDR_W-1:0] paddr,
  input  logic [ppma_pkg::DATA_W-1:0] pwdata,
  output logic [ppma_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import ppma_pkg::*;

  logic             fifo_full;
  logic             fifo_empty;
  logic             push;
  logic             pop;
  ppma_job_t        job_in;
  ppma_job_t        job_out;
  logic [WIN_W-1:0] window;

  assign pready = 1'b1;

  ppma_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pix_valid_i   (pix_i.valid),
    .pixel_value_i (pix_i.pixel_value),
    .pix_ready_o   (pix_i.ready),
    .fifo_full_i   (fifo_full),
    .push_o        (push),
    .job_o         (job_in),
    .window_o      (window)
  );

  ppma_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (job_in),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .pop_data_o  (job_out),
    .empty_o     (fifo_empty)
  );

  ppma_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_i            (job_out),
    .fifo_empty_i     (fifo_empty),
    .pop_o            (pop),
    .window_i         (window),
    .out_valid_o      (ped_o.valid),
    .out_ready_i      (ped_o.ready),
    .pedestal_o       (ped_o.pedestal),
    .pedestal_valid_o (ped_o.pedestal_valid),
    .end_of_frame_o   (ped_o.end_of_frame)
  );

endmodule

// ===== test/per_pixel_moving_average_pedestal_tb.sv =====
module per_pixel_moving_average_pedestal_tb;
  import ppma_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_LEN     = 150;
  localparam int HOLD_STRIDE  = 450;
  localparam int RANDOM_BEATS = 1350;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED = REG_IDX_W'(3);

  typedef struct packed {
    logic [PED_W-1:0] pedestal;
    logic             pedestal_valid;
    logic             end_of_frame;
  } ped_beat_t;

  logic                clk_i;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  ppma_pix_if pix ();
  ppma_ped_if ped ();

  per_pixel_moving_average_pedestal dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_n),
    .pix_i   (pix),
    .ped_o   (ped),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bit [SUM_W-1:0]       sum_mem [PIXELS];
  bit [SAMPLE_BITS-1:0] hist_mem [CELLS];
  int                   window_len;
  int                   span_x;
  int                   span_y;
  int                   frames_done;
  int                   hist_slot;
  int                   col_pos;
  int                   row_pos;

  logic [PIXEL_W-1:0] pending_pixels [$];
  ped_beat_t          expected_beats [$];

  int  errors;
  int  cycle_count;
  int  beats_queued;
  int  pixels_taken;
  int  results_seen;
  int  full_window_beats;
  int  inputs_blocked;
  int  long_holds;
  int  settings_done;
  bit  offer_taken;
  bit  src_idle_on;
  bit  snk_idle_on;
  int  send_gap;
  int  stall_left;
  int  hold_left;
  int  next_hold_at;

  function automatic int clamp_field(longint v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function void restart_scan();
    sum_mem = '{default: '0};
    frames_done = 0;
    hist_slot = 0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function void apply_register(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    case (idx)
      REG_WINDOW: begin
        window_len = clamp_field(data[WIN_W-1:0], MAX_WINDOW);
      end
      REG_COUNT_X: begin
        span_x = clamp_field(data[CNT_W-1:0], MAX_PIXELS_X);
      end
      REG_COUNT_Y: begin
        span_y = clamp_field(data[CNT_W-1:0], MAX_PIXELS_Y);
      end
      default: begin
        return;
      end
    endcase
    restart_scan();
  endfunction

  function ped_beat_t average_step(logic [PIXEL_W-1:0] raw);
    ped_beat_t beat;
    int        pix_idx;
    int        ring_idx;
    longint    acc;
    bit        warm;
    pix_idx = col_pos * MAX_PIXELS_Y + row_pos;
    ring_idx = hist_slot * PIXELS + pix_idx;
    warm = frames_done >= window_len;
    acc = sum_mem[pix_idx];
    beat.pedestal = '0;
    if (warm) begin
      beat.pedestal = PED_W'((acc << FRAC_W) / window_len);
      acc -= hist_mem[ring_idx];
    end
    acc += raw[SAMPLE_BITS-1:0];
    sum_mem[pix_idx] = SUM_W'(acc);
    hist_mem[ring_idx] = raw[SAMPLE_BITS-1:0];
    beat.pedestal_valid = warm;
    beat.end_of_frame = (col_pos + 1 >= span_x) && (row_pos + 1 >= span_y);
    if (row_pos + 1 >= span_y) begin
      row_pos = 0;
      if (col_pos + 1 >= span_x) begin
        col_pos = 0;
        if (frames_done < window_len) frames_done++;
        hist_slot = (hist_slot + 1 >= window_len) ? 0 : hist_slot + 1;
      end else begin
        col_pos++;
      end
    end else begin
      row_pos++;
    end
    return beat;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  function automatic logic [PIXEL_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return PIXEL_W'($urandom_range(0, 15));
      default: return PIXEL_W'($urandom);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pack_field(int raw, int w);
    logic [DATA_W-1:0] upper;
    upper = $urandom;
    if ($urandom_range(0, 3) == 0) return (upper << w) | DATA_W'(raw);
    return DATA_W'(raw);
  endfunction

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_n && pix.valid === 1'b1) begin
      if (pix.ready === 1'b1) begin
        offer_taken = 1'b1;
        expected_beats.push_back(average_step(pix.pixel_value));
        pending_pixels.delete(0);
        pixels_taken++;
      end else begin
        inputs_blocked++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_n && !(pix.valid && !offer_taken)) begin
      offer_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        pix.valid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        pix.valid <= 1'b1;
        pix.pixel_value <= pending_pixels[0];
        if (src_idle_on) send_gap = gap_len();
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        ped.ready <= 1'b0;
      end else if (results_seen >= next_hold_at) begin
        hold_left = HOLD_LEN - 1;
        next_hold_at += HOLD_STRIDE;
        long_holds++;
        ped.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ped.ready <= 1'b0;
      end else begin
        ped.ready <= 1'b1;
        if (snk_idle_on) stall_left = gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    ped_beat_t want;
    if (rst_n && ped.valid === 1'b1 && ped.ready === 1'b1) begin
      results_seen++;
      if (expected_beats.size() == 0) begin
        $error("pedestal beat with none expected: pedestal %0d", ped.pedestal);
        errors++;
      end else begin
        want = expected_beats[0];
        expected_beats.delete(0);
        if (want.pedestal_valid) full_window_beats++;
        if (ped.pedestal !== want.pedestal) begin
          $error("pedestal: expected %0d, actual %0d", want.pedestal, ped.pedestal);
          errors++;
        end
        if (ped.pedestal_valid !== want.pedestal_valid) begin
          $error("pedestal_valid: expected %0d, actual %0d",
                 want.pedestal_valid, ped.pedestal_valid);
          errors++;
        end
        if (ped.end_of_frame !== want.end_of_frame) begin
          $error("end_of_frame: expected %0d, actual %0d",
                 want.end_of_frame, ped.end_of_frame);
          errors++;
        end
      end
    end
  end

  task automatic settle();
    while (pending_pixels.size() != 0 || expected_beats.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    apply_register(idx, data);
  endtask

  task automatic queue_pixels(input int count, input bit all_max);
    repeat (count) begin
      pending_pixels.push_back(all_max ? '1 : pick_pixel());
      beats_queued++;
    end
  endtask

  task automatic run_phase(input int raw_w, input int raw_x, input int raw_y,
                           input logic [2:0] mask, input int extra, input bit all_max,
                           input bit split);
    int frame;
    int beats;
    int first;
    settle();
    src_idle_on = $urandom_range(0, 3) != 0;
    snk_idle_on = $urandom_range(0, 3) != 0;
    if (mask[0]) apb_write(REG_WINDOW, pack_field(raw_w, WIN_W));
    if (mask[1]) apb_write(REG_COUNT_X, pack_field(raw_x, CNT_W));
    if (mask[2]) apb_write(REG_COUNT_Y, pack_field(raw_y, CNT_W));
    settings_done++;
    frame = span_x * span_y;
    beats = frame * (window_len + extra);
    if (!all_max) beats += $urandom_range(0, frame - 1);
    first = split ? beats / 2 : beats;
    queue_pixels(first, all_max);
    if (split) begin
      settle();
      apb_write(REG_UNUSED, $urandom);
      queue_pixels(beats - first, all_max);
    end
  endtask

  initial begin
    int       raw_w;
    logic [2:0] mask;
    rst_n = 1'b0;
    pix.valid = 1'b0;
    pix.pixel_value = '0;
    ped.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    next_hold_at = 200;
    window_len = RST_WINDOW;
    span_x = RST_COUNT_X;
    span_y = RST_COUNT_Y;
    restart_scan();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    pending_pixels.push_back(16'h0000);
    pending_pixels.push_back(16'hFFFF);
    pending_pixels.push_back(16'h5555);
    pending_pixels.push_back(16'hAAAA);
    beats_queued += 4;
    run_phase(16, 1, 1, 3'b111, 2, 1'b1, 1'b0);

    beats_queued = 0;
    run_phase(0, 200, 0, 3'b111, 1, 1'b0, 1'b0);
    run_phase(1, 1, 255, 3'b111, 1, 1'b0, 1'b0);
    run_phase(31, 2, 1, 3'b111, 2, 1'b0, 1'b1);
    while (beats_queued < RANDOM_BEATS) begin
      case ($urandom_range(0, 7))
        0: raw_w = $urandom_range(17, 31);
        1: raw_w = 0;
        default: raw_w = $urandom_range(1, MAX_WINDOW);
      endcase
      mask = 3'b111;
      if (span_x * span_y <= 15 && $urandom_range(0, 3) == 0) begin
        mask = 3'($urandom_range(1, 7));
      end
      run_phase(raw_w, $urandom_range(1, 3), $urandom_range(1, 5), mask,
                $urandom_range(1, 3), 1'b0, $urandom_range(0, 3) == 0);
    end
    settle();

    $display("Sent %0d pixel beats under %0d register settings; %0d pedestal beats checked,",
             pixels_taken, settings_done, results_seen);
    $display("%0d with a full window; input blocked %0d cycles over %0d long output holds.",
             full_window_beats, inputs_blocked, long_holds);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
